/* design/acm_pkg.sv */
// acm_pkg: shared types, codes and constants of the autoranging current meter
// used by acm_front, acm_back and autorange_current_meter; no dependencies
package acm_pkg;

    localparam int GAIN_W   = 17;
    localparam int CUR_W    = 17;
    localparam int SAMPLE_W = 10;
    localparam int ROOM_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = SAMPLE_W + GAIN_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int NDIG = 6;
    localparam int DIG_IDX_W = $clog2(NDIG);
    localparam int DIG_CNT_W = $clog2(NDIG + 1);

    localparam logic [ROOM_W-1:0] MIN_ROOM = 16'd11;

    // divide by ten: q = (v * RECIP10) >> RECIP_SHIFT, exact for v below 2^18
    localparam int RECIP_W     = 16;
    localparam logic [RECIP_W-1:0] RECIP10 = 16'd52429;
    localparam int RECIP_SHIFT = 19;
    localparam int QUOT_W      = 14;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [1:0] KIND_MEAS  = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic [1:0] RANGE_LOW    = 2'd0;
    localparam logic [1:0] RANGE_MID    = 2'd1;
    localparam logic [1:0] RANGE_HIGH   = 2'd2;
    localparam logic [1:0] RANGE_UNUSED = 2'd3;

    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LOW         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MID         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_HIGH        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_LOW_TO_MID  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_MID_TO_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_MID_TO_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_HIGH_TO_MID = 3'd6;

    localparam logic [GAIN_W-1:0] RST_GAIN_LOW         = 17'd1320;
    localparam logic [GAIN_W-1:0] RST_GAIN_MID         = 17'd11000;
    localparam logic [GAIN_W-1:0] RST_GAIN_HIGH        = 17'd110000;
    localparam logic [CUR_W-1:0]  RST_RISE_LOW_TO_MID  = 17'd1000;
    localparam logic [CUR_W-1:0]  RST_RISE_MID_TO_HIGH = 17'd10000;
    localparam logic [CUR_W-1:0]  RST_FALL_MID_TO_LOW  = 17'd900;
    localparam logic [CUR_W-1:0]  RST_FALL_HIGH_TO_MID = 17'd9000;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample;
        logic [ROOM_W-1:0]   room;
    } t_in;

    typedef struct packed {
        logic [1:0]       kind;
        logic [CUR_W-1:0] current;
        logic [1:0]       range_now;
        logic [7:0]       char_code;
        logic             last;
    } t_out;

    // classified command between front and back
    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample;
        logic                room_ok;
    } t_cmd;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_low;
        logic [GAIN_W-1:0] gain_mid;
        logic [GAIN_W-1:0] gain_high;
        logic [CUR_W-1:0]  rise_low_to_mid;
        logic [CUR_W-1:0]  rise_mid_to_high;
        logic [CUR_W-1:0]  fall_mid_to_low;
        logic [CUR_W-1:0]  fall_high_to_mid;
    } t_cfg;

endpackage

/* design/acm_front.sv */
// acm_front: input transfer, room check and command queue
// depends on acm_pkg
module acm_front #(
    parameter int DEPTH = acm_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  acm_pkg::t_in  i_in,
    output logic          o_cmd_valid,
    output acm_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    acm_pkg::t_cmd r_q [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;
    acm_pkg::t_cmd cmd_in;

    assign o_in_ready  = (r_count != FULL_CNT);
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_comb begin
        cmd_in.op      = i_in.op;
        cmd_in.sample  = i_in.sample;
        cmd_in.room_ok = (i_in.room >= acm_pkg::MIN_ROOM);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* design/acm_back.sv */
// acm_back: command execution, range control, decimal conversion, result register
// depends on acm_pkg
module acm_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  acm_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    input  acm_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output acm_pkg::t_out o_out
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MEAS  = 7'b0000010,
        S_EMPTY = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_CHAR  = 7'b0010000,
        S_NL    = 7'b0100000,
        S_SPARE = 7'b1000000
    } t_state;

    localparam int PW = acm_pkg::PROD_W;
    localparam int CW = acm_pkg::CUR_W;
    localparam int DW = CW + acm_pkg::RECIP_W;

    t_state r_state, n_state;
    logic [1:0]    r_range, n_range;
    logic [CW-1:0] r_latest, n_latest;
    logic          r_fresh, n_fresh;
    logic [PW-1:0] r_prod, n_prod;
    logic [CW-1:0] r_val, n_val;
    logic [acm_pkg::DIG_CNT_W-1:0] r_cnt, n_cnt;
    acm_pkg::t_out r_out, n_out;
    logic          r_out_valid, n_out_valid;
    logic [3:0]    r_dig [acm_pkg::NDIG];

    logic          slot_free;
    logic          dig_we;
    logic [acm_pkg::GAIN_W-1:0] gain_sel;
    logic [CW-1:0] cur;
    logic [1:0]    range_nx;
    logic [DW-1:0] recip_prod;
    logic [acm_pkg::QUOT_W-1:0] quot;
    logic [CW-1:0] rem;
    logic [acm_pkg::DIG_CNT_W-1:0] rd_cnt;
    logic [3:0]    dig_rd;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        case (r_range)
            acm_pkg::RANGE_LOW: gain_sel = i_cfg.gain_low;
            acm_pkg::RANGE_MID: gain_sel = i_cfg.gain_mid;
            default:            gain_sel = i_cfg.gain_high;
        endcase
    end

    assign cur = r_prod[PW-1 -: CW];

    always_comb begin
        range_nx = r_range;
        case (r_range)
            acm_pkg::RANGE_LOW: begin
                if (cur > i_cfg.rise_low_to_mid) range_nx = acm_pkg::RANGE_MID;
            end
            acm_pkg::RANGE_MID: begin
                if (cur > i_cfg.rise_mid_to_high) range_nx = acm_pkg::RANGE_HIGH;
                else if (cur < i_cfg.fall_mid_to_low) range_nx = acm_pkg::RANGE_LOW;
            end
            default: begin
                if (cur < i_cfg.fall_high_to_mid) range_nx = acm_pkg::RANGE_MID;
            end
        endcase
    end

    // one decimal digit per cycle
    assign recip_prod = DW'(r_val) * DW'(acm_pkg::RECIP10);
    assign quot       = recip_prod[acm_pkg::RECIP_SHIFT +: acm_pkg::QUOT_W];
    assign rem        = r_val - (CW'(quot) << 3) - (CW'(quot) << 1);
    assign rd_cnt     = r_cnt - 1'b1;
    assign dig_rd     = r_dig[rd_cnt[acm_pkg::DIG_IDX_W-1:0]];

    always_comb begin
        n_state     = r_state;
        n_range     = r_range;
        n_latest    = r_latest;
        n_fresh     = r_fresh;
        n_prod      = r_prod;
        n_val       = r_val;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd_pop   = 1'b0;
        dig_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == acm_pkg::OP_SAMPLE) begin
                        n_prod  = PW'(i_cmd.sample) * PW'(gain_sel);
                        n_state = S_MEAS;
                    end else if (!i_cmd.room_ok || !r_fresh) begin
                        n_state = S_EMPTY;
                    end else begin
                        n_val   = r_latest;
                        n_fresh = 1'b0;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_MEAS: begin
                if (slot_free) begin
                    n_range           = range_nx;
                    n_latest          = cur;
                    n_fresh           = 1'b1;
                    n_out.kind        = acm_pkg::KIND_MEAS;
                    n_out.current     = cur;
                    n_out.range_now   = range_nx;
                    n_out.char_code   = '0;
                    n_out.last        = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (slot_free) begin
                    n_out.kind      = acm_pkg::KIND_EMPTY;
                    n_out.current   = '0;
                    n_out.range_now = r_range;
                    n_out.char_code = '0;
                    n_out.last      = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_DIV: begin
                dig_we = 1'b1;
                n_val  = CW'(quot);
                n_cnt  = r_cnt + 1'b1;
                if (quot == '0) n_state = S_CHAR;
            end
            S_CHAR: begin
                if (slot_free) begin
                    n_out.kind      = acm_pkg::KIND_CHAR;
                    n_out.current   = '0;
                    n_out.range_now = r_range;
                    n_out.char_code = acm_pkg::CHAR_ZERO + 8'(dig_rd);
                    n_out.last      = 1'b0;
                    n_out_valid     = 1'b1;
                    n_cnt           = rd_cnt;
                    if (rd_cnt == '0) n_state = S_NL;
                end
            end
            S_NL: begin
                if (slot_free) begin
                    n_out.kind      = acm_pkg::KIND_CHAR;
                    n_out.current   = '0;
                    n_out.range_now = r_range;
                    n_out.char_code = acm_pkg::CHAR_NEWLINE;
                    n_out.last      = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_range     <= acm_pkg::RANGE_HIGH;
            r_latest    <= '0;
            r_fresh     <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_range     <= n_range;
            r_latest    <= n_latest;
            r_fresh     <= n_fresh;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_val  <= n_val;
        r_out  <= n_out;
        if (dig_we) begin
            r_dig[r_cnt[acm_pkg::DIG_IDX_W-1:0]] <= rem[3:0];
        end
    end

    a_range_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_range != acm_pkg::RANGE_UNUSED)
        else $error("range register holds unused code");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= acm_pkg::DIG_CNT_W'(acm_pkg::NDIG))
        else $error("digit count beyond buffer");

    a_char_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHAR) |-> (r_cnt != '0))
        else $error("character state with no digit left");

    a_meas_sets_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MEAS && slot_free) |=> (r_fresh && r_out_valid && r_out.last))
        else $error("measurement did not mark value available");

    a_newline_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NL && slot_free) |=>
        (r_out_valid && r_out.last && r_out.kind == acm_pkg::KIND_CHAR
         && r_out.char_code == acm_pkg::CHAR_NEWLINE && r_state == S_IDLE))
        else $error("text transfer did not end with newline");

endmodule

/* design/autorange_current_meter.sv */
// autorange_current_meter: top level, configuration registers and the two halves
// depends on acm_pkg, acm_front, acm_back
//
// Three-range autoranging current meter. A sample item (op 0) is scaled by the
// gain of the active range, (sample * gain) >> 10, stored as the latest value,
// and the range then steps up or down against the hysteresis thresholds; one
// measurement result carries the current and the new range. A read item (op 1)
// with room of at least 11 and an unread value gives the value as decimal ASCII
// digits, most significant first, then a newline; otherwise it gives one empty
// result. Items enter a queue of DEPTH entries and are executed one at a time
// by the back end: a sample goes through the measure state, an empty read through
// the empty state, and a read through the one-digit-per-cycle divide by ten and
// then one result per cycle on the output register while the output is not stalled.
// Configuration writes take effect at once and are meant for when no item is in
// flight.
module autorange_current_meter #(
    parameter int DEPTH = acm_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  acm_pkg::t_in                   i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output acm_pkg::t_out                  o_out,
    input  logic                           i_cfg_we,
    input  logic [acm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [acm_pkg::GAIN_W-1:0]     i_cfg_data
);

    acm_pkg::t_cfg r_cfg;
    acm_pkg::t_cmd cmd;
    logic          cmd_valid;
    logic          cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_low         <= acm_pkg::RST_GAIN_LOW;
            r_cfg.gain_mid         <= acm_pkg::RST_GAIN_MID;
            r_cfg.gain_high        <= acm_pkg::RST_GAIN_HIGH;
            r_cfg.rise_low_to_mid  <= acm_pkg::RST_RISE_LOW_TO_MID;
            r_cfg.rise_mid_to_high <= acm_pkg::RST_RISE_MID_TO_HIGH;
            r_cfg.fall_mid_to_low  <= acm_pkg::RST_FALL_MID_TO_LOW;
            r_cfg.fall_high_to_mid <= acm_pkg::RST_FALL_HIGH_TO_MID;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                acm_pkg::CFG_GAIN_LOW:         r_cfg.gain_low         <= i_cfg_data;
                acm_pkg::CFG_GAIN_MID:         r_cfg.gain_mid         <= i_cfg_data;
                acm_pkg::CFG_GAIN_HIGH:        r_cfg.gain_high        <= i_cfg_data;
                acm_pkg::CFG_RISE_LOW_TO_MID:  r_cfg.rise_low_to_mid  <= i_cfg_data;
                acm_pkg::CFG_RISE_MID_TO_HIGH: r_cfg.rise_mid_to_high <= i_cfg_data;
                acm_pkg::CFG_FALL_MID_TO_LOW:  r_cfg.fall_mid_to_low  <= i_cfg_data;
                acm_pkg::CFG_FALL_HIGH_TO_MID: r_cfg.fall_high_to_mid <= i_cfg_data;
                default: ;
            endcase
        end
    end

    acm_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    acm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

/* verif/acm_checker.sv */
`timescale 1ns / 100ps
// acm_checker: watches the input, output and register ports of the current meter,
// predicts each result and compares it field by field; depends on acm_pkg
module acm_checker
    import acm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in                  i_in,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out                 i_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    t_cfg             meter_cfg;
    logic [1:0]       range_sel;
    logic [CUR_W-1:0] latest_current;
    logic             value_fresh;
    t_out             meter_results[$];
    int               mismatch_count = 0;
    int               results_waiting = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = results_waiting;

    function automatic void queue_result(logic [1:0] kind, logic [CUR_W-1:0] current,
                                         logic [7:0] char_code, logic last);
        t_out r;
        r.kind      = kind;
        r.current   = current;
        r.range_now = range_sel;
        r.char_code = char_code;
        r.last      = last;
        meter_results.push_back(r);
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [GAIN_W-1:0] data);
        case (idx)
            CFG_GAIN_LOW:         meter_cfg.gain_low         = data;
            CFG_GAIN_MID:         meter_cfg.gain_mid         = data;
            CFG_GAIN_HIGH:        meter_cfg.gain_high        = data;
            CFG_RISE_LOW_TO_MID:  meter_cfg.rise_low_to_mid  = data;
            CFG_RISE_MID_TO_HIGH: meter_cfg.rise_mid_to_high = data;
            CFG_FALL_MID_TO_LOW:  meter_cfg.fall_mid_to_low  = data;
            CFG_FALL_HIGH_TO_MID: meter_cfg.fall_high_to_mid = data;
            default: ;
        endcase
    endfunction

    function automatic void predict_measurement(t_in item);
        logic [GAIN_W-1:0] gain;
        logic [PROD_W-1:0] prod;
        logic [CUR_W-1:0]  cur;
        logic [7:0]        digits [NDIG];
        logic [CUR_W-1:0]  v;
        int                n;
        if (item.op == OP_SAMPLE) begin
            case (range_sel)
                RANGE_LOW: gain = meter_cfg.gain_low;
                RANGE_MID: gain = meter_cfg.gain_mid;
                default:   gain = meter_cfg.gain_high;
            endcase
            prod = item.sample * gain;
            cur  = prod[PROD_W-1:SAMPLE_W];
            case (range_sel)
                RANGE_LOW: begin
                    if (cur > meter_cfg.rise_low_to_mid) range_sel = RANGE_MID;
                end
                RANGE_MID: begin
                    if (cur > meter_cfg.rise_mid_to_high) range_sel = RANGE_HIGH;
                    else if (cur < meter_cfg.fall_mid_to_low) range_sel = RANGE_LOW;
                end
                default: begin
                    if (cur < meter_cfg.fall_high_to_mid) range_sel = RANGE_MID;
                end
            endcase
            latest_current = cur;
            value_fresh    = 1'b1;
            queue_result(KIND_MEAS, cur, 8'd0, 1'b1);
        end else if (item.room < MIN_ROOM || !value_fresh) begin
            queue_result(KIND_EMPTY, '0, 8'd0, 1'b1);
        end else begin
            value_fresh = 1'b0;
            v = latest_current;
            digits[0] = CHAR_ZERO + 8'(v % 10);
            v = v / 10;
            n = 1;
            while (v != 0 && n < NDIG) begin
                digits[n] = CHAR_ZERO + 8'(v % 10);
                v = v / 10;
                n++;
            end
            while (n > 0) begin
                n--;
                queue_result(KIND_CHAR, '0, digits[n], 1'b0);
            end
            queue_result(KIND_CHAR, '0, CHAR_NEWLINE, 1'b1);
        end
    endfunction

    function automatic void compare_field(string name, int unsigned exp_val,
                                          int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result(t_out got);
        t_out want;
        if (meter_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d current %0d",
                     $time, got.kind, got.current);
            mismatch_count++;
        end else begin
            want = meter_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("current", want.current, got.current);
            compare_field("range_now", want.range_now, got.range_now);
            compare_field("char_code", want.char_code, got.char_code);
            compare_field("last", want.last, got.last);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            meter_cfg.gain_low         = RST_GAIN_LOW;
            meter_cfg.gain_mid         = RST_GAIN_MID;
            meter_cfg.gain_high        = RST_GAIN_HIGH;
            meter_cfg.rise_low_to_mid  = RST_RISE_LOW_TO_MID;
            meter_cfg.rise_mid_to_high = RST_RISE_MID_TO_HIGH;
            meter_cfg.fall_mid_to_low  = RST_FALL_MID_TO_LOW;
            meter_cfg.fall_high_to_mid = RST_FALL_HIGH_TO_MID;
            range_sel      = RANGE_HIGH;
            latest_current = '0;
            value_fresh    = 1'b0;
            meter_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_result(i_out);
            if (i_in_valid && i_in_ready) predict_measurement(i_in);
            if (i_cfg_we) apply_register(i_cfg_idx, i_cfg_data);
        end
        results_waiting = meter_results.size();
    end

endmodule

/* verif/tb_autorange_current_meter.sv */
`timescale 1ns / 100ps
// tb_autorange_current_meter: stimulus, register settings and verdict for the meter
// depends on acm_pkg, autorange_current_meter and acm_checker
module tb_autorange_current_meter;
    import acm_pkg::*;

    localparam int WATCHDOG_LIMIT   = 500;
    localparam int RANDOM_PER_PHASE = 36;
    localparam int NUM_PHASES       = 5;
    localparam int END_WAIT         = 20;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in                  in_item = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out                 out_item;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [GAIN_W-1:0]    cfg_data = '0;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles = 0;
    int                   send_quiet = 0;
    int                   recv_quiet = 0;

    autorange_current_meter u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    acm_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // draws a random idle gap, with occasional stretches of none
    function automatic int draw_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            quiet = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    function automatic t_in make_item(logic op, int unsigned sample, int unsigned room);
        t_in it;
        it.op     = op;
        it.sample = SAMPLE_W'(sample);
        it.room   = ROOM_W'(room);
        return it;
    endfunction

    function automatic t_in random_item();
        t_in it;
        it.op     = ($urandom_range(0, 9) < 6) ? OP_SAMPLE : OP_READ;
        it.sample = ($urandom_range(0, 3) == 0) ? SAMPLE_W'($urandom_range(0, 63))
                                                : SAMPLE_W'($urandom_range(0, 1023));
        it.room   = ($urandom_range(0, 7) == 0) ? ROOM_W'($urandom_range(0, 10))
                                                : ROOM_W'($urandom_range(11, 65535));
        return it;
    endfunction

    // called and returns at a falling edge; valid stays high for back-to-back items
    task automatic send_item(input t_in item);
        int gap;
        gap = draw_wait(send_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    task automatic write_config(input t_cfg c);
        write_reg(CFG_GAIN_LOW, c.gain_low);
        write_reg(CFG_GAIN_MID, c.gain_mid);
        write_reg(CFG_GAIN_HIGH, c.gain_high);
        write_reg(CFG_RISE_LOW_TO_MID, c.rise_low_to_mid);
        write_reg(CFG_RISE_MID_TO_HIGH, c.rise_mid_to_high);
        write_reg(CFG_FALL_MID_TO_LOW, c.fall_mid_to_low);
        write_reg(CFG_FALL_HIGH_TO_MID, c.fall_high_to_mid);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending != 0) @(negedge clk);
    endtask

    // result side: stall for a drawn number of cycles before each transfer
    initial begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            stall = draw_wait(recv_quiet);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial begin
        t_cfg phase_cfg;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: empty reads, zero value, six digits, every range move
        send_item(make_item(OP_READ, 0, 11));
        send_item(make_item(OP_SAMPLE, 0, 0));
        send_item(make_item(OP_READ, 1023, 10));
        send_item(make_item(OP_READ, 0, 11));
        send_item(make_item(OP_READ, 0, 11));
        send_item(make_item(OP_SAMPLE, 1023, 65535));
        send_item(make_item(OP_SAMPLE, 1023, 0));
        send_item(make_item(OP_READ, 0, 65535));
        send_item(make_item(OP_SAMPLE, 50, 0));
        send_item(make_item(OP_SAMPLE, 50, 0));
        send_item(make_item(OP_READ, 0, 0));
        send_item(make_item(OP_READ, 0, 12));
        send_item(make_item(OP_SAMPLE, 1023, 0));
        send_item(make_item(OP_SAMPLE, 85, 0));
        send_item(make_item(OP_SAMPLE, 82, 0));
        send_item(make_item(OP_SAMPLE, 700, 0));
        send_item(make_item(OP_SAMPLE, 767, 16'h5555));
        send_item(make_item(OP_READ, 10'h2AA, 16'hAAAA));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            in_valid <= 1'b0;
            drain_results();
            case (ph)
                0: phase_cfg = '1;
                1: phase_cfg = '0;
                4: begin
                    phase_cfg.gain_low         = RST_GAIN_LOW;
                    phase_cfg.gain_mid         = RST_GAIN_MID;
                    phase_cfg.gain_high        = RST_GAIN_HIGH;
                    phase_cfg.rise_low_to_mid  = RST_RISE_LOW_TO_MID;
                    phase_cfg.rise_mid_to_high = RST_RISE_MID_TO_HIGH;
                    phase_cfg.fall_mid_to_low  = RST_FALL_MID_TO_LOW;
                    phase_cfg.fall_high_to_mid = RST_FALL_HIGH_TO_MID;
                end
                default: begin
                    phase_cfg.gain_low         = GAIN_W'($urandom_range(0, 131071));
                    phase_cfg.gain_mid         = GAIN_W'($urandom_range(0, 131071));
                    phase_cfg.gain_high        = GAIN_W'($urandom_range(0, 131071));
                    phase_cfg.rise_low_to_mid  = CUR_W'($urandom_range(0, 131071));
                    phase_cfg.rise_mid_to_high = CUR_W'($urandom_range(0, 131071));
                    phase_cfg.fall_mid_to_low  = CUR_W'($urandom_range(0, 131071));
                    phase_cfg.fall_high_to_mid = CUR_W'($urandom_range(0, 131071));
                end
            endcase
            write_config(phase_cfg);
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                send_item(random_item());
            end
        end

        in_valid <= 1'b0;
        drain_results();
        repeat (END_WAIT) @(negedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* autorange_current_meter.f */
design/acm_pkg.sv
design/acm_front.sv
design/acm_back.sv
design/autorange_current_meter.sv
verif/acm_checker.sv
verif/tb_autorange_current_meter.sv
